/* rtl/core/bdq_pkg.sv */
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants for the bounded deque with search.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int DATA_W        = 32;
  localparam int CMD_W         = 3;
  localparam int STATUS_W      = 2;
  localparam int DEPTH_DEFAULT = 16;

  // Command codes. Codes above CMD_SEARCH are no-ops.
  localparam logic [CMD_W-1:0] CMD_PUSH_HEAD = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_TAIL = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_HEAD  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_TAIL  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SEARCH    = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  // Value returned by a pop on an empty deque.
  localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_SEARCH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]   result_value;
    logic                       found;
    logic        [STATUS_W-1:0] status;
  } result_t;

endpackage

/* rtl/core/bdq_if.sv */
// ----------------------------------------------------------------------------
// bdq_if
// Valid/ready channels for deque requests and their results.
// ----------------------------------------------------------------------------
interface bdq_cmd_if;
  logic                                valid;
  logic                                ready;
  logic        [bdq_pkg::CMD_W-1:0]    command;
  logic signed [bdq_pkg::DATA_W-1:0]   value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

interface bdq_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [bdq_pkg::DATA_W-1:0]   result_value;
  logic                                found;
  logic        [bdq_pkg::STATUS_W-1:0] status;

  modport source (output valid, output result_value, output found, output status,
                  input ready);
  modport sink   (input valid, input result_value, input found, input status,
                  output ready);
endinterface

/* rtl/core/bdq_ram.sv */
// ----------------------------------------------------------------------------
// bdq_ram
// Ring storage: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bdq_ram #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic                               clk,
  input  logic                               we,
  input  logic [IDX_W-1:0]                   waddr,
  input  logic signed [bdq_pkg::DATA_W-1:0]  wdata,
  input  logic [IDX_W-1:0]                   raddr,
  output logic signed [bdq_pkg::DATA_W-1:0]  rdata
);

  logic signed [bdq_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/bdq_ctrl.sv */
// ----------------------------------------------------------------------------
// bdq_ctrl
// Sequencer for the deque: pointer update, pop read-back and the serial
// search that runs one shared compare over the live entries.
// ----------------------------------------------------------------------------
module bdq_ctrl #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT,
  parameter int IDX_W = $clog2(DEPTH),
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                               clk,
  input  logic                               rst,
  bdq_cmd_if.sink                            cmd_ch,
  bdq_res_if.source                          res_ch,
  output logic                               ram_we,
  output logic [IDX_W-1:0]                   ram_waddr,
  output logic signed [bdq_pkg::DATA_W-1:0]  ram_wdata,
  output logic [IDX_W-1:0]                   ram_raddr,
  input  logic signed [bdq_pkg::DATA_W-1:0]  ram_rdata
);

  bdq_pkg::state_t state, state_next;

  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] tail;
  logic [CNT_W-1:0] occ;
  logic [IDX_W-1:0] scan_ptr;
  logic [CNT_W-1:0] scan_cnt;
  logic signed [bdq_pkg::DATA_W-1:0] key;
  bdq_pkg::result_t pend;
  bdq_pkg::result_t pend_init;

  logic accept;
  logic full;
  logic empty;
  logic match;
  logic scan_last;
  logic out_free;

  function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
    return (p == IDX_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] ptr_dec(input logic [IDX_W-1:0] p);
    return (p == '0) ? IDX_W'(DEPTH - 1) : p - 1'b1;
  endfunction

  assign accept    = cmd_ch.valid && cmd_ch.ready;
  assign full      = (occ == CNT_W'(DEPTH));
  assign empty     = (occ == '0);
  assign match     = (ram_rdata == key);
  assign scan_last = ((scan_cnt + 1'b1) == occ);
  assign out_free  = !res_ch.valid || res_ch.ready;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      bdq_pkg::ST_IDLE: begin
        if (accept) begin
          if ((cmd_ch.command == bdq_pkg::CMD_POP_HEAD ||
               cmd_ch.command == bdq_pkg::CMD_POP_TAIL) && !empty) begin
            state_next = bdq_pkg::ST_POP;
          end else if (cmd_ch.command == bdq_pkg::CMD_SEARCH && !empty) begin
            state_next = bdq_pkg::ST_SEARCH;
          end else begin
            state_next = bdq_pkg::ST_DONE;
          end
        end
      end
      bdq_pkg::ST_POP: begin
        state_next = bdq_pkg::ST_DONE;
      end
      bdq_pkg::ST_SEARCH: begin
        if (match || scan_last) begin
          state_next = bdq_pkg::ST_DONE;
        end
      end
      bdq_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = bdq_pkg::ST_IDLE;
        end
      end
      default: state_next = bdq_pkg::ST_IDLE;
    endcase
  end

  // Handshake and storage port controls.
  always_comb begin
    cmd_ch.ready = (state == bdq_pkg::ST_IDLE);
    ram_we       = accept && !full &&
                   (cmd_ch.command == bdq_pkg::CMD_PUSH_HEAD ||
                    cmd_ch.command == bdq_pkg::CMD_PUSH_TAIL);
    ram_waddr    = (cmd_ch.command == bdq_pkg::CMD_PUSH_HEAD) ? ptr_dec(head) : tail;
    ram_wdata    = cmd_ch.value;
    // While scanning, fetch the next entry so one compare happens per cycle.
    if (state == bdq_pkg::ST_SEARCH) begin
      ram_raddr = ptr_inc(scan_ptr);
    end else if (cmd_ch.command == bdq_pkg::CMD_POP_TAIL) begin
      ram_raddr = ptr_dec(tail);
    end else begin
      ram_raddr = head;
    end
  end

  // Result as far as it is known when the request is taken.
  always_comb begin
    pend_init = '0;
    if ((cmd_ch.command == bdq_pkg::CMD_PUSH_HEAD ||
         cmd_ch.command == bdq_pkg::CMD_PUSH_TAIL) && full) begin
      pend_init.status = bdq_pkg::STATUS_FULL;
    end
    if ((cmd_ch.command == bdq_pkg::CMD_POP_HEAD ||
         cmd_ch.command == bdq_pkg::CMD_POP_TAIL) && empty) begin
      pend_init.result_value = bdq_pkg::EMPTY_VALUE;
      pend_init.status       = bdq_pkg::STATUS_EMPTY;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= bdq_pkg::ST_IDLE;
      head         <= '0;
      tail         <= '0;
      occ          <= '0;
      res_ch.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == bdq_pkg::ST_DONE && out_free) begin
        res_ch.valid <= 1'b1;
      end else if (res_ch.valid && res_ch.ready) begin
        res_ch.valid <= 1'b0;
      end
      if (accept) begin
        unique case (cmd_ch.command)
          bdq_pkg::CMD_PUSH_HEAD: begin
            if (!full) begin
              head <= ptr_dec(head);
              occ  <= occ + 1'b1;
            end
          end
          bdq_pkg::CMD_PUSH_TAIL: begin
            if (!full) begin
              tail <= ptr_inc(tail);
              occ  <= occ + 1'b1;
            end
          end
          bdq_pkg::CMD_POP_HEAD: begin
            if (!empty) begin
              head <= ptr_inc(head);
              occ  <= occ - 1'b1;
            end
          end
          bdq_pkg::CMD_POP_TAIL: begin
            if (!empty) begin
              tail <= ptr_dec(tail);
              occ  <= occ - 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Request key, scan position and pending result.
  always_ff @(posedge clk) begin
    if (accept) begin
      key      <= cmd_ch.value;
      scan_ptr <= head;
      scan_cnt <= '0;
      pend     <= pend_init;
    end
    if (state == bdq_pkg::ST_POP) begin
      pend.result_value <= ram_rdata;
    end
    if (state == bdq_pkg::ST_SEARCH) begin
      if (match) begin
        pend.found <= 1'b1;
      end
      scan_ptr <= ptr_inc(scan_ptr);
      scan_cnt <= scan_cnt + 1'b1;
    end
    if (state == bdq_pkg::ST_DONE && out_free) begin
      res_ch.result_value <= pend.result_value;
      res_ch.found        <= pend.found;
      res_ch.status       <= pend.status;
    end
  end

endmodule

/* rtl/core/bounded_deque_with_search.sv */
// ----------------------------------------------------------------------------
// bounded_deque_with_search
// Bounded double-ended queue of signed 32-bit values with a value search.
// ----------------------------------------------------------------------------
// Requests arrive on cmd_ch (command, value) and each one gives exactly one
// result on res_ch (result_value, found, status), in request order.
// Commands push at the head or tail, pop from the head or tail, or search
// the live entries for value. A push into a full deque is dropped with
// status full; a pop from an empty deque returns -1 with status empty.
// A push, an empty pop, a no-op or an empty search goes from idle to done;
// a pop passes through a read state first; a search compares entries up to
// a match or the last live one, at most DEPTH. The search runs one compare
// per cycle, paced by the single read port of the ring storage.
// cmd_ch.ready is high only while the sequencer is idle, so one request is
// in flight at a time. A finished result sits in the output register; while
// the receiver stalls, the block still takes the next request and holds its
// result until the output register frees up.
// Reset empties the deque (head, tail and count to zero) and drops any
// pending result. Storage contents are not cleared and need no clearing.
// ----------------------------------------------------------------------------
module bounded_deque_with_search #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  bdq_cmd_if.sink    cmd_ch,
  bdq_res_if.source  res_ch
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                              ram_we;
  logic [IDX_W-1:0]                  ram_waddr;
  logic signed [bdq_pkg::DATA_W-1:0] ram_wdata;
  logic [IDX_W-1:0]                  ram_raddr;
  logic signed [bdq_pkg::DATA_W-1:0] ram_rdata;

  bdq_ctrl #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_ch    (cmd_ch),
    .res_ch    (res_ch),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  bdq_ram #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
